/* design/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants
// Sizes, register indexes and the queue entry of the sprite pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  localparam int MAX_LINES = 256;
  localparam int MAX_PAIRS = 4;

  localparam int WORD_W  = 16;              // plane word width, pixels per line word
  localparam int XPOS_W  = 4;               // pixel position within a segment
  localparam int ROW_W   = $clog2(MAX_LINES);
  localparam int POS_W   = $clog2(MAX_LINES + 2);
  localparam int PAIR_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int STRIP_W = $clog2(2 * MAX_PAIRS);
  localparam int LCNT_W  = 9;
  localparam int PCNT_W  = 3;
  localparam int COL_W   = 6;
  localparam int IDX_W   = 5;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic REG_LINE_COUNT = 1'b0;
  localparam logic REG_PAIR_COUNT = 1'b1;

  localparam logic [LCNT_W-1:0] LINE_COUNT_RST = LCNT_W'(16);
  localparam logic [PCNT_W-1:0] PAIR_COUNT_RST = PCNT_W'(1);

  // one line segment handed from the front to the back
  typedef struct packed {
    logic [WORD_W-1:0]   plane_a;
    logic [WORD_W-1:0]   plane_b;
    logic [2*WORD_W-1:0] even;      // {B,A} of the matching even line
    logic [ROW_W-1:0]    row;
    logic [PAIR_W-1:0]   pair;
    logic                attached;
    logic                frame_end;
  } spc_cmd_t;

endpackage

`default_nettype wire

/* design/spc_front.sv */
// ----------------------------------------------------------------------------
// spc_front: group classifier
// Tracks strip and line position, keeps even strip lines, issues segments.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_front import spc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 grp_valid,
  input  wire logic [WORD_W-1:0]    grp_a,
  input  wire logic [WORD_W-1:0]    grp_b,
  input  wire logic [LCNT_W-1:0]    line_count,
  input  wire logic [PCNT_W-1:0]    pair_count,
  input  wire logic [QCNT_W-1:0]    q_count,
  output logic                      grp_ready,
  output logic                      push,
  output spc_cmd_t                  push_cmd
);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [STRIP_W-1:0]  strip_r, strip_nxt;
  logic [LCNT_W-1:0]   lines;
  logic [PCNT_W-1:0]   pairs;
  logic [STRIP_W:0]    strips;
  logic [ROW_W-1:0]    y;
  logic                acc, is_hdr, is_ftr, is_line, is_even, emit;
  logic                s1_valid_r;
  spc_cmd_t            s1_cmd_r;
  logic [2*WORD_W-1:0] rd_data_r;
  logic [2*WORD_W-1:0] store_mem [MAX_LINES];

  // effective settings
  always_comb begin
    lines = (line_count > LCNT_W'(MAX_LINES)) ? LCNT_W'(MAX_LINES) : line_count;
    if (pair_count == '0) begin
      pairs = PCNT_W'(1);
    end else if (pair_count > PCNT_W'(MAX_PAIRS)) begin
      pairs = PCNT_W'(MAX_PAIRS);
    end else begin
      pairs = pair_count;
    end
    strips = (pairs == PCNT_W'(1)) ? (STRIP_W+1)'(1) : (STRIP_W+1)'({pairs, 1'b0});
  end

  // room for this word plus the one in the read stage
  assign grp_ready = ({1'b0, q_count} + (QCNT_W+1)'(s1_valid_r)) < (QCNT_W+1)'(QDEPTH);
  assign acc       = grp_valid & grp_ready;

  always_comb begin
    is_hdr  = (pos_r == '0);
    is_ftr  = !is_hdr && ({1'b0, pos_r} >= ({1'b0, lines} + (POS_W+1)'(1)));
    is_line = !is_hdr && !is_ftr;
    y       = ROW_W'(pos_r - POS_W'(1));
    is_even = (pairs != PCNT_W'(1)) && !strip_r[0];
    emit    = acc && is_line && !is_even;
    pos_nxt   = pos_r;
    strip_nxt = strip_r;
    if (acc) begin
      if (is_ftr) begin
        pos_nxt   = '0;
        strip_nxt = (({1'b0, strip_r} + (STRIP_W+1)'(1)) >= strips)
                    ? '0 : STRIP_W'(strip_r + STRIP_W'(1));
      end else begin
        pos_nxt = POS_W'(pos_r + POS_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      strip_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      strip_r    <= strip_nxt;
      s1_valid_r <= emit;
    end
  end

  // even line store: written on even strips, read for odd strips
  always_ff @(posedge clk) begin
    if (acc && is_line && is_even) begin
      store_mem[y] <= {grp_b, grp_a};
    end
    if (emit) begin
      rd_data_r <= store_mem[y];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_cmd_r.plane_a   <= grp_a;
      s1_cmd_r.plane_b   <= grp_b;
      s1_cmd_r.even      <= '0;
      s1_cmd_r.row       <= y;
      s1_cmd_r.pair      <= (pairs == PCNT_W'(1)) ? '0 : PAIR_W'(strip_r >> 1);
      s1_cmd_r.attached  <= (pairs != PCNT_W'(1));
      s1_cmd_r.frame_end <= ({1'b0, strip_r} == (strips - (STRIP_W+1)'(1))) &&
                            ({1'b0, y} == (lines - LCNT_W'(1)));
    end
  end

  always_comb begin
    push_cmd      = s1_cmd_r;
    push_cmd.even = rd_data_r;
  end
  assign push = s1_valid_r;

endmodule

`default_nettype wire

/* design/spc_queue.sv */
// ----------------------------------------------------------------------------
// spc_queue: segment queue
// Small FIFO between classifier and pixel emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_queue import spc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire spc_cmd_t      push_cmd,
  input  wire logic          pop,
  output spc_cmd_t           head,
  output logic               empty,
  output logic [QCNT_W-1:0]  count
);

  spc_cmd_t            ent_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + QCNT_W'(1));
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - QCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + QPTR_W'(1));
      end
      if (pop) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + QPTR_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head  = ent_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

`default_nettype wire

/* design/spc_back.sv */
// ----------------------------------------------------------------------------
// spc_back: pixel emitter
// Walks a segment leftmost pixel first and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_back import spc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire spc_cmd_t      head,
  input  wire logic          empty,
  output logic               pop,
  output logic               pix_valid,
  input  wire logic          pix_ready,
  output logic [ROW_W-1:0]   pix_row,
  output logic [COL_W-1:0]   pix_column,
  output logic [IDX_W-1:0]   pix_index,
  output logic               pix_line_done,
  output logic               pix_frame_done
);

  logic [XPOS_W-1:0]  x_r;
  logic               load, last;
  logic [XPOS_W-1:0]  bitsel;
  logic [3:0]         v;
  logic [IDX_W-1:0]   idx;
  logic               valid_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [IDX_W-1:0]   idx_r;
  logic               ldone_r, fdone_r;

  assign load   = !empty && (!valid_r || pix_ready);
  assign last   = (x_r == '1);
  assign pop    = load && last;
  assign bitsel = ~x_r;            // bit 15 goes out first

  always_comb begin
    v = {head.plane_b[bitsel], head.plane_a[bitsel],
         head.even[WORD_W + 32'(bitsel)], head.even[bitsel]};
    if (!head.attached) begin
      idx = IDX_W'({head.plane_b[bitsel], head.plane_a[bitsel]});
    end else if (v == '0) begin
      idx = '0;
    end else begin
      idx = {1'b1, v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        x_r     <= XPOS_W'(x_r + XPOS_W'(1));
        valid_r <= 1'b1;
      end else if (pix_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r   <= head.row;
      col_r   <= COL_W'({head.pair, x_r});
      idx_r   <= idx;
      ldone_r <= last;
      fdone_r <= last && head.frame_end;
    end
  end

  assign pix_valid      = valid_r;
  assign pix_row        = row_r;
  assign pix_column     = col_r;
  assign pix_index      = idx_r;
  assign pix_line_done  = ldone_r;
  assign pix_frame_done = fdone_r;

endmodule

`default_nettype wire

/* design/sprite_planar_to_chunky_top.sv */
// ----------------------------------------------------------------------------
// sprite_planar_to_chunky_top: sprite bitplane to pixel converter
// Turns a stream of two-plane sprite words into indexed pixels with position.
// ----------------------------------------------------------------------------
// Each input word carries plane A in bits 15:0 and plane B in bits 31:16.
// A strip is one header word, line_count line words and one footer word;
// header and footer give no pixels. With pair_count 0 or 1 every line word
// gives 16 pixels (index B<<1|A). With 2 or more pairs (at most 4) the strips
// come in even/odd pairs: even lines are kept in a 256-entry line store and
// each odd line is merged with its even partner into a 4-bit value, sent as
// 16+value, or 0 when transparent. Pixels leave leftmost first, one per cycle
// while the output is not stalled; header, footer and even-strip words are
// hidden behind a 4-entry segment queue feeding the single pixel output
// register. A line word passes the read stage register, the segment queue
// and the output register before its first pixel appears. Configuration is
// taken any time but should be written only while the block is idle; the
// counters restart after the last strip of a sprite.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_planar_to_chunky_top import spc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // [15:0] plane_a_word, [31:16] plane_b_word
  // pixel stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [23:0]               out_tdata,  // [7:0] pixel_row, [13:8] pixel_column,
                                                // [18:14] pixel_index, [23:19] zero
  output logic                      out_tuser,  // [0] line_done
  output logic                      out_tlast,  // frame_done
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,  // 0 line_count, 1 pair_count
  input  wire logic [LCNT_W-1:0]    cfg_data
);

  logic [LCNT_W-1:0]  line_count_r;
  logic [PCNT_W-1:0]  pair_count_r;

  logic               push, pop, q_empty;
  spc_cmd_t           push_cmd, q_head;
  logic [QCNT_W-1:0]  q_count;

  logic [ROW_W-1:0]   pix_row;
  logic [COL_W-1:0]   pix_column;
  logic [IDX_W-1:0]   pix_index;

  // registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= LINE_COUNT_RST;
      pair_count_r <= PAIR_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_COUNT: line_count_r <= cfg_data;
        REG_PAIR_COUNT: pair_count_r <= cfg_data[PCNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // front: header/footer skip, even-line store, segment issue
  spc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (in_tvalid),
    .grp_a      (in_tdata[WORD_W-1:0]),
    .grp_b      (in_tdata[2*WORD_W-1:WORD_W]),
    .line_count (line_count_r),
    .pair_count (pair_count_r),
    .q_count    (q_count),
    .grp_ready  (in_tready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  spc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  // back: one pixel per cycle into the output register while the output is not stalled
  spc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (pop),
    .pix_valid      (out_tvalid),
    .pix_ready      (out_tready),
    .pix_row        (pix_row),
    .pix_column     (pix_column),
    .pix_index      (pix_index),
    .pix_line_done  (out_tuser),
    .pix_frame_done (out_tlast)
  );

  assign out_tdata = {5'b0, pix_index, pix_column, pix_row};

endmodule

`default_nettype wire

/* design/spc_checker.sv */
// ----------------------------------------------------------------------------
// spc_checker: port-level checks
// Watches the converter's ports and flags inconsistent pixel words.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        out_tlast
);

  // frame end only on a line end
  a_last_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end without line end");

  // line end exactly at the rightmost pixel of a segment
  a_line_end_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[11:8] == 4'hF)))
    else $error("line end does not match column");

  // indexes 4..16 never occur
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[18:14] < 5'd4 || out_tdata[18:14] > 5'd16))
    else $error("pixel index out of range");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled pixel word changed");

endmodule

bind sprite_planar_to_chunky_top spc_checker u_spc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* sim/tb_sprite_planar_to_chunky_top.sv */
// ----------------------------------------------------------------------------
// tb_sprite_planar_to_chunky_top: self-checking bench for the sprite converter
// Streams sprite words with random idling on both sides and predicts every
// pixel word in the bench. Each pixel is checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sprite_planar_to_chunky_top;
  import spc_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // cycles without any handshake
  localparam int SETTLE_TICKS = 32;    // no-pixel words still in flight
  localparam int PRINT_CAP    = 20;    // keep the log short on a bad build

  // one expected pixel word
  typedef struct packed {
    logic [7:0]       row;
    logic [COL_W-1:0] col;
    logic [IDX_W-1:0] idx;
    logic             line_end;
    logic             frame_end;
  } pixel_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // [15:0] plane_a_word, [31:16] plane_b_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [7:0] row, [13:8] column, [18:14] index, [23:19] zero
  logic        out_tuser;        // [0] line_done
  logic        out_tlast;        // frame_done
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = REG_LINE_COUNT;
  logic [LCNT_W-1:0] cfg_data = '0;

  sprite_planar_to_chunky_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Pixel predictor: register copies, strip counters and the even line store.
  // --------------------------------------------------------------------------
  logic [LCNT_W-1:0] cur_lines = LINE_COUNT_RST;
  logic [PCNT_W-1:0] cur_pairs = PAIR_COUNT_RST;
  int                group_pos = 0;   // 0 header, 1..L line, L+1 footer
  int                strip_no  = 0;
  logic [31:0]       even_lines [MAX_LINES];  // {B,A}

  pixel_t pending_pixels[$];

  int  words_sent  = 0;
  int  pixels_seen = 0;
  int  reg_writes  = 0;
  int  mismatches  = 0;
  bit  no_idle     = 1'b0;  // both sides run flat out while set

  function automatic void predict_pixels(input logic [15:0] a, input logic [15:0] b);
    int          lines;
    int          pairs;
    int          strips;
    int          row;
    int          pair_no;
    bit          frame_hit;
    logic [31:0] even;
    logic [3:0]  v;
    pixel_t      px;
    lines  = (cur_lines > MAX_LINES) ? MAX_LINES : int'(cur_lines);
    pairs  = (cur_pairs == 0) ? 1 : ((cur_pairs > MAX_PAIRS) ? MAX_PAIRS : int'(cur_pairs));
    strips = (pairs == 1) ? 1 : 2 * pairs;
    if (group_pos == 0) begin
      group_pos = 1;
      return;
    end
    // footer; also taken when a shorter line count was written mid-strip
    if (group_pos >= lines + 1) begin
      group_pos = 0;
      strip_no  = (strip_no + 1 >= strips) ? 0 : strip_no + 1;
      return;
    end
    row = group_pos - 1;
    group_pos++;
    if (pairs == 1) begin
      pair_no = 0;
    end else if (strip_no % 2 == 0) begin
      even_lines[row] = {b, a};  // even strip only fills the store
      return;
    end else begin
      pair_no = strip_no / 2;
    end
    frame_hit = (strip_no == strips - 1) && (row == lines - 1);
    even      = even_lines[row];
    for (int x = 0; x < WORD_W; x++) begin
      if (pairs == 1) begin
        px.idx = {3'b000, b[15-x], a[15-x]};
      end else begin
        v      = {b[15-x], a[15-x], even[31-x], even[15-x]};
        px.idx = (v == 4'd0) ? 5'd0 : {1'b1, v};  // 16 + v
      end
      px.row       = row[7:0];
      px.col       = COL_W'(pair_no * 16 + x);
      px.line_end  = (x == 15);
      px.frame_end = (x == 15) && frame_hit;
      pending_pixels.push_back(px);
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] plane_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Pixel side: random back-pressure and in-order checking.
  // --------------------------------------------------------------------------
  int rdy_hold = 0;

  always @(posedge clk) begin : ready_gen
    int stall;
    if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      stall = gap_len();
      out_tready <= (stall == 0);
      rdy_hold   <= (stall == 0) ? $urandom_range(0, 12) : stall - 1;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] pixel %0d: %s got %0d want %0d", $realtime, pixels_seen, what, got,
               want);
    mismatches++;
  endtask

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, row", out_tdata[7:0], -1);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[7:0] !== want.row)       report_mismatch("row", out_tdata[7:0], want.row);
        if (out_tdata[13:8] !== want.col)      report_mismatch("column", out_tdata[13:8], want.col);
        if (out_tdata[18:14] !== want.idx)     report_mismatch("index", out_tdata[18:14], want.idx);
        if (out_tdata[23:19] !== 5'd0)         report_mismatch("pad bits", out_tdata[23:19], 0);
        if (out_tuser !== want.line_end)       report_mismatch("line_done", out_tuser, want.line_end);
        if (out_tlast !== want.frame_end)      report_mismatch("frame_done", out_tlast, want.frame_end);
      end
      pixels_seen++;
    end
  end

  // Watchdog: any handshake restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d pixels outstanding",
               quiet_cycles, pending_pixels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Sends one sprite word; valid stays up when the next word follows at once.
  task automatic send_word(input logic [15:0] a, input logic [15:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixels(a, b);
    words_sent++;
  endtask

  task automatic send_random_words(input int count);
    for (int i = 0; i < count; i++) send_word(plane_word(), plane_word());
  endtask

  // Header, one line, footer.
  task automatic send_one_line_strip(input logic [15:0] a, input logic [15:0] b);
    send_word(plane_word(), plane_word());
    send_word(a, b);
    send_word(plane_word(), plane_word());
  endtask

  // Drain all pixels, then give header/footer/even words time to retire.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Both registers back to back; valid stays high between the two words.
  task automatic set_config(input logic [LCNT_W-1:0] lines, input logic [LCNT_W-1:0] pairs);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LINE_COUNT;
    cfg_data  <= lines;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_lines = lines;
    cfg_index <= REG_PAIR_COUNT;
    cfg_data  <= pairs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_pairs = pairs[PCNT_W-1:0];
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Simple strip: transparent, full color and alternating planes.
  task automatic test_simple_patterns();
    wait_idle();
    set_config(9'd3, 9'd1);
    send_word(16'h0000, 16'h0000);  // header
    send_word(16'h0000, 16'h0000);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'hAAAA, 16'h5555);
    send_word(16'hFFFF, 16'hFFFF);  // footer
  endtask

  // Zero line count gives bare header/footer; zero pair count acts as simple.
  task automatic test_empty_and_zero_pairs();
    wait_idle();
    set_config(9'd0, 9'd1);
    send_random_words(2);
    wait_idle();
    set_config(9'd1, 9'd1);
    set_config(9'd1, 9'd0);
    send_one_line_strip(plane_word(), plane_word());
  endtask

  // Saturated line count with two pairs: the even strip fills store rows 0..3,
  // then the line count drops below the current position so the next word is
  // taken as the footer, and the odd strip reads the four rows back. Then the
  // pair count drops mid-sprite (strip number past the new last strip) and
  // the line count drops again, so the next word is taken as the footer.
  task automatic test_tall_attached();
    wait_idle();
    set_config(9'd511, 9'd2);
    send_random_words(5);           // header and rows 0..3 of the even strip
    wait_idle();
    set_config(9'd4, 9'd2);
    send_random_words(1);           // footer of the even strip
    send_random_words(6);           // odd strip, four lines
    wait_idle();
    set_config(9'd511, 9'd1);
    send_random_words(3);
    wait_idle();
    set_config(9'd1, 9'd1);
    send_random_words(1);           // footer, strip counter wraps
    send_random_words(3);           // clean one-line sprite
  endtask

  // Oversized pair count saturates to four pairs; columns reach 63.
  task automatic test_wide_attached();
    wait_idle();
    set_config(9'd1, 9'd7);
    send_one_line_strip(16'h0000, 16'h0000);
    send_one_line_strip(16'h0000, 16'h0000);
    send_one_line_strip(16'hFFFF, 16'hFFFF);
    send_one_line_strip(16'hFFFF, 16'hFFFF);
    send_one_line_strip(16'hAAAA, 16'hCCCC);  // with the next strip: all 16 combos
    send_one_line_strip(16'hF0F0, 16'hFF00);
    send_one_line_strip(plane_word(), plane_word());
    send_one_line_strip(plane_word(), plane_word());
  endtask

  // Random sprites; some are cut short so the next register write lands
  // mid-sprite.
  task automatic test_random_sprites();
    int first;
    int lines;
    int pairs_raw;
    int pairs;
    int count;
    first = words_sent;
    while (words_sent - first < 100) begin
      lines     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      pairs_raw = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
      pairs     = (pairs_raw == 0) ? 1 : ((pairs_raw > MAX_PAIRS) ? MAX_PAIRS : pairs_raw);
      count     = ((pairs == 1) ? 1 : 2 * pairs) * (lines + 2);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      set_config(LCNT_W'(lines), {6'($urandom_range(0, 63)), 3'(pairs_raw)});
      send_random_words(count);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_simple_patterns();
    test_empty_and_zero_pairs();
    test_tall_attached();
    test_wide_attached();
    test_random_sprites();
    wait_idle();

    $display("Sent %0d sprite words, checked %0d pixels, made %0d register writes.",
             words_sent, pixels_seen, reg_writes);
    $display("Line counts 0..511, pair counts 0..7, simple and attached, mid-sprite changes.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
